FILE: src/voxel_ray_trace_cost_grid_core_macros.svh
`ifndef VOXEL_RAY_TRACE_COST_GRID_CORE_MACROS_SVH
`define VOXEL_RAY_TRACE_COST_GRID_CORE_MACROS_SVH

// Concurrent checks on the rising edge of clk_i, held off while rst_ni is low.
`define VRTCG_ASSERT(lbl, prop, msg) \
  lbl: assert property (@(posedge clk_i) disable iff (!rst_ni) (prop)) else $error(msg);

`define VRTCG_ASSERT_IMPL(lbl, ante, cons, msg) \
  lbl: assert property (@(posedge clk_i) disable iff (!rst_ni) (ante) |-> (cons)) \
    else $error(msg);

`define VRTCG_ASSERT_NEXT(lbl, ante, cons, msg) \
  lbl: assert property (@(posedge clk_i) disable iff (!rst_ni) (ante) |=> (cons)) \
    else $error(msg);

`endif

FILE: src/vrtcg_pkg.sv
`timescale 1ns / 1ps
package vrtcg_pkg;

  localparam int DEF_X_CELLS = 32;
  localparam int DEF_Y_CELLS = 32;
  localparam int DEF_Z_CELLS = 32;

  localparam int CRD_W  = 8;
  localparam int FRAC_W = 18;

  localparam logic [1:0] CMD_CLEAR = 2'd0;
  localparam logic [1:0] CMD_ADD   = 2'd1;
  localparam logic [1:0] CMD_QUERY = 2'd2;

  localparam logic [1:0] ST_DONE  = 2'd0;
  localparam logic [1:0] ST_RANGE = 2'd1;
  localparam logic [1:0] ST_GRID  = 2'd2;

  localparam logic [1:0] CFG_INV_RES   = 2'd0;
  localparam logic [1:0] CFG_MAX_RANGE = 2'd1;
  localparam logic [1:0] CFG_FREE_LIM  = 2'd2;
  localparam logic [1:0] CFG_BUSY_LIM  = 2'd3;

  localparam logic [7:0] COST_FREE = 8'd255;

  typedef struct packed {
    logic [1:0]         cmd;
    logic signed [15:0] pos_x;
    logic signed [15:0] pos_y;
    logic signed [15:0] pos_z;
    logic               occupied_only;
    logic [4:0]         query_x;
    logic [4:0]         query_y;
    logic [4:0]         query_z;
  } vrtcg_in_t;

  typedef struct packed {
    logic [1:0] status;
    logic [7:0] cost;
  } vrtcg_out_t;

  typedef struct packed {
    logic [15:0] inv_resolution;
    logic [15:0] max_range;
    logic [15:0] free_limit;
    logic [15:0] busy_limit;
  } vrtcg_cfg_t;

  typedef enum logic [1:0] {OP_CLEAR, OP_ADD, OP_QUERY, OP_NOP} vrtcg_op_e;

  typedef struct packed {
    vrtcg_op_e              op;
    logic [1:0]             status;
    logic                   occ_only;
    logic [2:0][CRD_W-1:0]  crd;
  } vrtcg_item_t;

  typedef enum logic [1:0] {F_IDLE, F_CALC, F_PUSH} vrtcg_front_e;

  typedef enum logic [2:0] {
    B_SWEEP, B_IDLE, B_ADDR, B_RD, B_EXEC, B_SETUP, B_DIV
  } vrtcg_back_e;

  typedef enum logic [1:0] {M_MARK, M_BUMP, M_QUERY} vrtcg_mode_e;

endpackage

FILE: src/vrtcg_fifo.sv
`timescale 1ns / 1ps
module vrtcg_fifo import vrtcg_pkg::*; (
  input  logic        clk_i,
  input  logic        rst_ni,
  input  logic        push_i,
  input  vrtcg_item_t item_i,
  input  logic        pop_i,
  output vrtcg_item_t item_o,
  output logic        full_o,
  output logic        empty_o
);

  vrtcg_item_t mem_q [2];
  logic        wptr_q, wptr_d, rptr_q, rptr_d;
  logic [1:0]  cnt_q, cnt_d;

  always_comb begin
    wptr_d = push_i ? ~wptr_q : wptr_q;
    rptr_d = pop_i ? ~rptr_q : rptr_q;
    cnt_d  = cnt_q + 2'(push_i) - 2'(pop_i);
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      wptr_q <= 1'b0;
      rptr_q <= 1'b0;
      cnt_q  <= 2'd0;
    end else begin
      wptr_q <= wptr_d;
      rptr_q <= rptr_d;
      cnt_q  <= cnt_d;
    end
  end

  always_ff @(posedge clk_i) begin
    if (push_i) begin
      mem_q[wptr_q] <= item_i;
    end
  end

  assign item_o  = mem_q[rptr_q];
  assign full_o  = (cnt_q == 2'd2);
  assign empty_o = (cnt_q == 2'd0);

endmodule

FILE: src/vrtcg_front.sv
`timescale 1ns / 1ps
module vrtcg_front import vrtcg_pkg::*; #(
  parameter int X_CELLS = DEF_X_CELLS,
  parameter int Y_CELLS = DEF_Y_CELLS,
  parameter int Z_CELLS = DEF_Z_CELLS
) (
  input  logic        clk_i,
  input  logic        rst_ni,
  input  logic        start_i,
  output logic        busy_o,
  input  vrtcg_in_t   in_i,
  input  vrtcg_cfg_t  cfg_i,
  input  logic        full_i,
  output logic        push_o,
  output vrtcg_item_t item_o
);

  localparam logic [CRD_W-1:0] CAM_X = CRD_W'(X_CELLS / 2);
  localparam logic [CRD_W-1:0] CAM_Y = CRD_W'(Y_CELLS / 2);

  vrtcg_front_e         state_q, state_d;
  vrtcg_in_t            in_q;
  logic [2:0]           step_q;
  logic [33:0]          r2_q;
  logic [31:0]          mr2_q;
  logic [2:0][CRD_W-1:0] crd_q;
  logic [2:0]           ok_q;

  logic [2:0][15:0]     pos;
  logic [1:0]           axis;
  logic signed [16:0]   mul_a, mul_b;
  logic signed [33:0]   prod;
  logic [34:0]          s_val, s_mag, cam_sh;
  logic [16:0]          hi, cells;
  logic                 map_ok;
  logic [CRD_W-1:0]     map_idx;
  logic                 q_ok;

  assign pos  = {in_q.pos_z, in_q.pos_y, in_q.pos_x};
  assign axis = step_q[1:0];

  always_comb begin
    if (step_q == 3'd3) begin
      mul_a = $signed({1'b0, cfg_i.max_range});
      mul_b = $signed({1'b0, cfg_i.max_range});
    end else if (step_q < 3'd3) begin
      mul_a = $signed({pos[axis][15], pos[axis]});
      mul_b = $signed({pos[axis][15], pos[axis]});
    end else begin
      mul_a = $signed({pos[axis][15], pos[axis]});
      mul_b = $signed({1'b0, cfg_i.inv_resolution});
    end
    prod = mul_a * mul_b;
  end

  always_comb begin
    case (axis)
      2'd0:    begin cam_sh = 35'(CAM_X) << FRAC_W; cells = 17'(X_CELLS); end
      2'd1:    begin cam_sh = 35'(CAM_Y) << FRAC_W; cells = 17'(Y_CELLS); end
      default: begin cam_sh = 35'd0;                cells = 17'(Z_CELLS); end
    endcase
    s_val   = {prod[33], prod} + cam_sh;
    s_mag   = s_val[34] ? (35'd0 - s_val) : s_val;
    hi      = s_mag[34:FRAC_W];
    map_ok  = s_val[34] ? (hi == 17'd0) : (hi < cells);
    map_idx = s_val[34] ? '0 : hi[CRD_W-1:0];
  end

  assign q_ok = (9'(in_q.query_x) < 9'(X_CELLS)) && (9'(in_q.query_y) < 9'(Y_CELLS)) &&
                (9'(in_q.query_z) < 9'(Z_CELLS));

  always_comb begin
    state_d = state_q;
    unique case (state_q)
      F_IDLE: begin
        if (start_i) begin
          state_d = (in_i.cmd == CMD_ADD) ? F_CALC : F_PUSH;
        end
      end
      F_CALC: begin
        if (step_q == 3'd6) begin
          state_d = F_PUSH;
        end
      end
      F_PUSH: begin
        if (!full_i) begin
          state_d = F_IDLE;
        end
      end
      default: state_d = F_IDLE;
    endcase
  end

  always_comb begin
    busy_o          = (state_q != F_IDLE);
    push_o          = (state_q == F_PUSH) && !full_i;
    item_o.op       = OP_NOP;
    item_o.status   = ST_DONE;
    item_o.occ_only = in_q.occupied_only;
    item_o.crd      = crd_q;
    case (in_q.cmd)
      CMD_CLEAR: item_o.op = OP_CLEAR;
      CMD_ADD: begin
        item_o.op = OP_ADD;
        if (r2_q > 34'(mr2_q)) begin
          item_o.status = ST_RANGE;
        end else if (ok_q != 3'b111) begin
          item_o.status = ST_GRID;
        end
      end
      CMD_QUERY: begin
        item_o.crd = {CRD_W'(in_q.query_z), CRD_W'(in_q.query_y), CRD_W'(in_q.query_x)};
        if (q_ok) begin
          item_o.op = OP_QUERY;
        end else begin
          item_o.status = ST_GRID;
        end
      end
      default: item_o.op = OP_NOP;
    endcase
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      state_q <= F_IDLE;
    end else begin
      state_q <= state_d;
    end
  end

  always_ff @(posedge clk_i) begin
    if (state_q == F_IDLE && start_i) begin
      in_q   <= in_i;
      step_q <= 3'd0;
      r2_q   <= '0;
    end else if (state_q == F_CALC) begin
      if (step_q < 3'd3) begin
        r2_q <= r2_q + prod;
      end else if (step_q == 3'd3) begin
        mr2_q <= prod[31:0];
      end else begin
        crd_q[axis] <= map_idx;
        ok_q[axis]  <= map_ok;
      end
      step_q <= step_q + 3'd1;
    end
  end

endmodule

FILE: src/vrtcg_back.sv
`timescale 1ns / 1ps
module vrtcg_back import vrtcg_pkg::*; #(
  parameter int X_CELLS = DEF_X_CELLS,
  parameter int Y_CELLS = DEF_Y_CELLS,
  parameter int Z_CELLS = DEF_Z_CELLS
) (
  input  logic        clk_i,
  input  logic        rst_ni,
  input  vrtcg_cfg_t  cfg_i,
  input  logic        empty_i,
  input  vrtcg_item_t item_i,
  output logic        pop_o,
  output logic        init_o,
  output logic        res_valid_o,
  output vrtcg_out_t  res_o
);

  localparam int CELL_TOTAL = X_CELLS * Y_CELLS * Z_CELLS;
  localparam int AW = $clog2(CELL_TOTAL);
  localparam logic [CRD_W-1:0] CAM_X = CRD_W'(X_CELLS / 2);
  localparam logic [CRD_W-1:0] CAM_Y = CRD_W'(Y_CELLS / 2);
  localparam int EW = CRD_W + 3;

  logic [16:0] mem [CELL_TOTAL];

  vrtcg_back_e              state_q, state_d;
  vrtcg_mode_e              mode_q;
  vrtcg_item_t              item_q;
  logic [2:0][CRD_W-1:0]    p_q, cam;
  logic [2:0]               neg_q;
  logic [2:0][CRD_W:0]      dbl_q;
  logic [1:0]               a_q, b_q, c_q;
  logic signed [EW-1:0]     e1_q, e2_q;
  logic [CRD_W-1:0]         cnt_q;
  logic [AW-1:0]            addr_q, sweep_q;
  logic                     sweep_res_q;
  logic [16:0]              rdata_q;
  logic [15:0]              peak_q;
  logic                     any_q;
  logic [23:0]              num_q;
  logic [7:0]               quo_q;
  logic [2:0]               bit_q;
  logic                     res_valid_q;
  vrtcg_out_t               res_q;

  logic                     mem_we;
  logic [AW-1:0]            mem_waddr, addr_d;
  logic [16:0]              mem_wdata;
  logic                     emit;
  vrtcg_out_t               emit_res;
  logic                     sweep_last;
  logic [15:0]              cnt_inc, v, diff;
  logic                     need_div;
  logic [7:0]               q_cost;
  logic [23:0]              sub;
  logic                     ge;
  logic [7:0]               quo_nx;
  logic [2:0][CRD_W:0]      d_s;
  logic [2:0][CRD_W-1:0]    len_s;
  logic [1:0]               a_s, b_s, c_s;
  logic [2:0][CRD_W-1:0]    p_nx;
  logic signed [EW-1:0]     e1_nx, e2_nx;

  assign cam        = {CRD_W'(0), CAM_Y, CAM_X};
  assign sweep_last = (sweep_q == AW'(CELL_TOTAL - 1));
  assign init_o     = (state_q == B_SWEEP) && !sweep_res_q;
  assign addr_d     = AW'(32'(p_q[0]) * 32'(Y_CELLS * Z_CELLS) + 32'(p_q[1]) * 32'(Z_CELLS) +
                          32'(p_q[2]));

  // Walk setup: pick the driving axis and seed both error terms.
  always_comb begin
    for (int k = 0; k < 3; k++) begin
      d_s[k]   = {1'b0, item_q.crd[k]} - {1'b0, cam[k]};
      len_s[k] = d_s[k][CRD_W] ? CRD_W'(-d_s[k]) : d_s[k][CRD_W-1:0];
    end
    if (len_s[0] >= len_s[1] && len_s[0] >= len_s[2]) begin
      a_s = 2'd0; b_s = 2'd1; c_s = 2'd2;
    end else if (len_s[1] >= len_s[0] && len_s[1] >= len_s[2]) begin
      a_s = 2'd1; b_s = 2'd0; c_s = 2'd2;
    end else begin
      a_s = 2'd2; b_s = 2'd1; c_s = 2'd0;
    end
  end

  // One Bresenham step.
  always_comb begin
    p_nx  = p_q;
    e1_nx = e1_q + EW'(dbl_q[b_q]);
    e2_nx = e2_q + EW'(dbl_q[c_q]);
    if (e1_q > 0) begin
      p_nx[b_q] = neg_q[b_q] ? p_q[b_q] - 1'b1 : p_q[b_q] + 1'b1;
      e1_nx     = e1_nx - EW'(dbl_q[a_q]);
    end
    if (e2_q > 0) begin
      p_nx[c_q] = neg_q[c_q] ? p_q[c_q] - 1'b1 : p_q[c_q] + 1'b1;
      e2_nx     = e2_nx - EW'(dbl_q[a_q]);
    end
    p_nx[a_q] = neg_q[a_q] ? p_q[a_q] - 1'b1 : p_q[a_q] + 1'b1;
  end

  always_comb begin
    v        = rdata_q[15:0];
    cnt_inc  = (v == 16'hFFFF) ? v : v + 16'd1;
    diff     = peak_q - v;
    need_div = 1'b0;
    q_cost   = 8'd0;
    if (!any_q || rdata_q[16]) begin
      q_cost = 8'd0;
    end else if (v <= cfg_i.free_limit) begin
      q_cost = COST_FREE;
    end else if (v > cfg_i.busy_limit) begin
      q_cost = 8'd0;
    end else if (peak_q == 16'd0) begin
      q_cost = COST_FREE;
    end else begin
      need_div = 1'b1;
    end
    sub    = 24'(peak_q) << bit_q;
    ge     = (num_q >= sub);
    quo_nx = quo_q | (8'(ge) << bit_q);
  end

  always_comb begin
    state_d = state_q;
    unique case (state_q)
      B_SWEEP: if (sweep_last) state_d = B_IDLE;
      B_IDLE: begin
        if (!empty_i) begin
          unique case (item_i.op)
            OP_CLEAR: state_d = B_SWEEP;
            OP_ADD:   state_d = (item_i.status == ST_DONE) ? B_ADDR : B_IDLE;
            OP_QUERY: state_d = B_ADDR;
            default:  state_d = B_IDLE;
          endcase
        end
      end
      B_ADDR: state_d = B_RD;
      B_RD:   state_d = B_EXEC;
      B_EXEC: begin
        unique case (mode_q)
          M_MARK:  state_d = item_q.occ_only ? B_IDLE : B_SETUP;
          M_BUMP:  state_d = (cnt_q == '0) ? B_IDLE : B_ADDR;
          default: state_d = need_div ? B_DIV : B_IDLE;
        endcase
      end
      B_SETUP: state_d = B_ADDR;
      B_DIV:   if (bit_q == 3'd0) state_d = B_IDLE;
      default: state_d = B_IDLE;
    endcase
  end

  always_comb begin
    pop_o           = (state_q == B_IDLE) && !empty_i;
    mem_we          = 1'b0;
    mem_waddr       = addr_q;
    mem_wdata       = '0;
    emit            = 1'b0;
    emit_res.status = ST_DONE;
    emit_res.cost   = 8'd0;
    unique case (state_q)
      B_SWEEP: begin
        mem_we    = 1'b1;
        mem_waddr = sweep_q;
        emit      = sweep_last && sweep_res_q;
      end
      B_IDLE: begin
        if (!empty_i) begin
          emit_res.status = item_i.status;
          emit = (item_i.op == OP_NOP) ||
                 ((item_i.op == OP_ADD) && (item_i.status != ST_DONE));
        end
      end
      B_EXEC: begin
        unique case (mode_q)
          M_MARK: begin
            mem_we    = 1'b1;
            mem_wdata = {1'b1, v};
            emit      = item_q.occ_only;
          end
          M_BUMP: begin
            mem_we    = 1'b1;
            mem_wdata = {rdata_q[16], cnt_inc};
            emit      = (cnt_q == '0);
          end
          default: begin
            emit          = !need_div;
            emit_res.cost = q_cost;
          end
        endcase
      end
      B_DIV: begin
        emit          = (bit_q == 3'd0);
        emit_res.cost = quo_nx;
      end
      default: emit = 1'b0;
    endcase
  end

  always_ff @(posedge clk_i) begin
    rdata_q <= mem[addr_q];
    if (mem_we) begin
      mem[mem_waddr] <= mem_wdata;
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      state_q     <= B_SWEEP;
      sweep_q     <= '0;
      sweep_res_q <= 1'b0;
      peak_q      <= 16'd0;
      any_q       <= 1'b0;
      res_valid_q <= 1'b0;
    end else begin
      state_q     <= state_d;
      res_valid_q <= emit;
      if (state_q == B_SWEEP) begin
        sweep_q <= sweep_last ? '0 : sweep_q + 1'b1;
      end
      if (pop_o) begin
        if (item_i.op == OP_CLEAR) begin
          sweep_res_q <= 1'b1;
          peak_q      <= 16'd0;
          any_q       <= 1'b0;
        end else if (item_i.op == OP_ADD) begin
          any_q <= 1'b1;
        end
      end
      if (state_q == B_EXEC && mode_q == M_BUMP && cnt_inc > peak_q) begin
        peak_q <= cnt_inc;
      end
    end
  end

  always_ff @(posedge clk_i) begin
    if (emit) begin
      res_q <= emit_res;
    end
    unique case (state_q)
      B_IDLE: begin
        item_q <= item_i;
        p_q    <= item_i.crd;
        mode_q <= (item_i.op == OP_QUERY) ? M_QUERY : M_MARK;
      end
      B_ADDR: addr_q <= addr_d;
      B_EXEC: begin
        if (mode_q == M_BUMP) begin
          p_q   <= p_nx;
          e1_q  <= e1_nx;
          e2_q  <= e2_nx;
          cnt_q <= cnt_q - 1'b1;
        end
        num_q <= {diff, 8'd0} - 24'(diff);
        quo_q <= 8'd0;
        bit_q <= 3'd7;
      end
      B_SETUP: begin
        p_q    <= cam;
        mode_q <= M_BUMP;
        a_q    <= a_s;
        b_q    <= b_s;
        c_q    <= c_s;
        cnt_q  <= len_s[a_s];
        for (int k = 0; k < 3; k++) begin
          neg_q[k] <= d_s[k][CRD_W];
          dbl_q[k] <= {len_s[k], 1'b0};
        end
        e1_q <= EW'({len_s[b_s], 1'b0}) - EW'(len_s[a_s]);
        e2_q <= EW'({len_s[c_s], 1'b0}) - EW'(len_s[a_s]);
      end
      B_DIV: begin
        if (ge) begin
          num_q <= num_q - sub;
        end
        quo_q <= quo_nx;
        bit_q <= bit_q - 3'd1;
      end
      default: begin
        quo_q <= quo_q;
      end
    endcase
  end

  assign res_valid_o = res_valid_q;
  assign res_o       = res_q;

endmodule

FILE: src/voxel_ray_trace_cost_grid_core.sv
`timescale 1ns / 1ps
// Commands are taken at a rising edge with start high and busy low; each gives one result
// beat on result_o, marked by result_valid_o for a single cycle, which the receiver must
// take as it comes. The front end passes a clear or query straight on; for an add point it
// steps one shared multiplier through three squares, the range square and three axis
// mappings. Each command is then parked in a two-entry queue. The back end is bound by the
// grid memory and its registered read: a clear sweeps all X_CELLS*Y_CELLS*Z_CELLS voxels
// at one per cycle (32768 by default), an add point marks its cell and, unless
// occupied_only is set, bumps the L+1 cells of the walk, L being the largest axis distance
// from the camera cell, and a query reads its cell and may run a bit-serial cost divide.
// After reset the same sweep clears the grid while busy stays high.
`include "voxel_ray_trace_cost_grid_core_macros.svh"
module voxel_ray_trace_cost_grid_core import vrtcg_pkg::*; #(
  parameter int X_CELLS = DEF_X_CELLS,
  parameter int Y_CELLS = DEF_Y_CELLS,
  parameter int Z_CELLS = DEF_Z_CELLS
) (
  input  logic        clk_i,
  input  logic        rst_ni,
  input  logic        start,
  output logic        busy,
  input  vrtcg_in_t   cmd_i,
  input  logic        cfg_we_i,
  input  logic [1:0]  cfg_idx_i,
  input  logic [15:0] cfg_data_i,
  output logic        result_valid_o,
  output vrtcg_out_t  result_o
);

  vrtcg_cfg_t  cfg_q;
  vrtcg_item_t push_item, pop_item;
  logic        push, pop, full, empty, front_busy, init;

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      cfg_q.inv_resolution <= 16'd2560;
      cfg_q.max_range      <= 16'd5120;
      cfg_q.free_limit     <= 16'd0;
      cfg_q.busy_limit     <= 16'hFFFF;
    end else if (cfg_we_i) begin
      unique case (cfg_idx_i)
        CFG_INV_RES:   cfg_q.inv_resolution <= cfg_data_i;
        CFG_MAX_RANGE: cfg_q.max_range      <= cfg_data_i;
        CFG_FREE_LIM:  cfg_q.free_limit     <= cfg_data_i;
        CFG_BUSY_LIM:  cfg_q.busy_limit     <= cfg_data_i;
        default:       cfg_q.busy_limit     <= cfg_q.busy_limit;
      endcase
    end
  end

  assign busy = front_busy || init;

  vrtcg_front #(.X_CELLS(X_CELLS), .Y_CELLS(Y_CELLS), .Z_CELLS(Z_CELLS)) u_front (
    .clk_i   (clk_i),
    .rst_ni  (rst_ni),
    .start_i (start && !init),
    .busy_o  (front_busy),
    .in_i    (cmd_i),
    .cfg_i   (cfg_q),
    .full_i  (full),
    .push_o  (push),
    .item_o  (push_item)
  );

  vrtcg_fifo u_fifo (
    .clk_i   (clk_i),
    .rst_ni  (rst_ni),
    .push_i  (push),
    .item_i  (push_item),
    .pop_i   (pop),
    .item_o  (pop_item),
    .full_o  (full),
    .empty_o (empty)
  );

  vrtcg_back #(.X_CELLS(X_CELLS), .Y_CELLS(Y_CELLS), .Z_CELLS(Z_CELLS)) u_back (
    .clk_i       (clk_i),
    .rst_ni      (rst_ni),
    .cfg_i       (cfg_q),
    .empty_i     (empty),
    .item_i      (pop_item),
    .pop_o       (pop),
    .init_o      (init),
    .res_valid_o (result_valid_o),
    .res_o       (result_o)
  );

  `VRTCG_ASSERT(a_no_push_full, !(push && full), "queue written while full")
  `VRTCG_ASSERT(a_no_pop_empty, !(pop && empty), "queue read while empty")
  `VRTCG_ASSERT_NEXT(a_busy_after_start, start && !busy, busy, "busy not raised after a beat")
  `VRTCG_ASSERT_IMPL(a_err_no_cost, result_valid_o && (result_o.status != ST_DONE),
                     result_o.cost == 8'd0, "nonzero cost on a failed command")

endmodule

FILE: test/tb_voxel_ray_trace_cost_grid_core.sv
`timescale 1ns / 1ps
module tb_voxel_ray_trace_cost_grid_core;
  import vrtcg_pkg::*;

  localparam int NX = DEF_X_CELLS;
  localparam int NY = DEF_Y_CELLS;
  localparam int NZ = DEF_Z_CELLS;
  localparam int VOXELS = NX * NY * NZ;
  localparam int PHASE_ITEMS = 350;

  typedef struct {
    vrtcg_in_t  cmd;
    bit         typed;
    vrtcg_out_t res;
  } stim_row_t;

  logic        clk_i = 1'b0;
  logic        rst_ni = 1'b0;
  logic        start = 1'b0;
  logic        busy;
  vrtcg_in_t   cmd_i = '0;
  logic        cfg_we_i = 1'b0;
  logic [1:0]  cfg_idx_i = '0;
  logic [15:0] cfg_data_i = '0;
  logic        result_valid_o;
  vrtcg_out_t  result_o;

  logic [15:0] grid_count [VOXELS];
  bit          grid_occ [VOXELS];
  logic [15:0] peak_count;
  bit          seen_point;
  vrtcg_cfg_t  cfg;

  vrtcg_out_t  pending_results [$];
  int          mismatches = 0;
  int          results_seen = 0;
  int          n_add = 0, n_query = 0, n_clear = 0, n_nop = 0, n_walk_hits = 0;
  bit          no_gaps = 1'b0;

  always begin
    #1 clk_i = 1'b1;
    #1 clk_i = 1'b0;
  end

  voxel_ray_trace_cost_grid_core i_dut (
    .clk_i, .rst_ni, .start, .busy, .cmd_i,
    .cfg_we_i, .cfg_idx_i, .cfg_data_i,
    .result_valid_o, .result_o
  );

  function automatic int voxel_at(int x, int y, int z);
    return (x * NY + y) * NZ + z;
  endfunction

  function automatic void clear_grid();
    for (int i = 0; i < VOXELS; i++) begin
      grid_count[i] = '0;
      grid_occ[i] = 1'b0;
    end
    peak_count = '0;
    seen_point = 1'b0;
  endfunction

  function automatic void count_visit(int x, int y, int z);
    int i;
    if (x < 0 || x >= NX || y < 0 || y >= NY || z < 0 || z >= NZ) return;
    i = voxel_at(x, y, z);
    if (grid_count[i] != 16'hFFFF) grid_count[i]++;
    if (grid_count[i] > peak_count) peak_count = grid_count[i];
  endfunction

  function automatic longint axis_index(logic signed [15:0] pos, int cam);
    longint s;
    s = longint'(pos) * longint'(cfg.inv_resolution) + (longint'(cam) << FRAC_W);
    if (s >= 0) return s >>> FRAC_W;
    return -((-s) >>> FRAC_W);
  endfunction

  function automatic void trace_ray(int px, int py, int pz, int dx, int dy, int dz);
    int p[3], d[3], inc[3], len[3], dbl[3];
    int a, b, c, e1, e2;
    p[0] = px; p[1] = py; p[2] = pz;
    d[0] = dx; d[1] = dy; d[2] = dz;
    for (int k = 0; k < 3; k++) begin
      inc[k] = d[k] < 0 ? -1 : 1;
      len[k] = d[k] < 0 ? -d[k] : d[k];
      dbl[k] = 2 * len[k];
    end
    if (len[0] >= len[1] && len[0] >= len[2]) begin
      a = 0; b = 1; c = 2;
    end else if (len[1] >= len[0] && len[1] >= len[2]) begin
      a = 1; b = 0; c = 2;
    end else begin
      a = 2; b = 1; c = 0;
    end
    e1 = dbl[b] - len[a];
    e2 = dbl[c] - len[a];
    for (int i = 0; i < len[a]; i++) begin
      count_visit(p[0], p[1], p[2]);
      if (e1 > 0) begin
        p[b] += inc[b];
        e1 -= dbl[a];
      end
      if (e2 > 0) begin
        p[c] += inc[c];
        e2 -= dbl[a];
      end
      e1 += dbl[b];
      e2 += dbl[c];
      p[a] += inc[a];
    end
    count_visit(p[0], p[1], p[2]);
  endfunction

  function automatic vrtcg_out_t predict_grid(vrtcg_in_t c);
    vrtcg_out_t r;
    longint r2, mr2, ix, iy, iz;
    int i;
    int unsigned v, pk;
    r = '0;
    case (c.cmd)
      CMD_CLEAR: begin
        clear_grid();
        n_clear++;
      end
      CMD_ADD: begin
        n_add++;
        seen_point = 1'b1;
        r2 = longint'(c.pos_x) * c.pos_x + longint'(c.pos_y) * c.pos_y
           + longint'(c.pos_z) * c.pos_z;
        mr2 = longint'(cfg.max_range) * longint'(cfg.max_range);
        if (r2 > mr2) begin
          r.status = ST_RANGE;
        end else begin
          ix = axis_index(c.pos_x, NX / 2);
          iy = axis_index(c.pos_y, NY / 2);
          iz = axis_index(c.pos_z, 0);
          if (ix < 0 || ix >= NX || iy < 0 || iy >= NY || iz < 0 || iz >= NZ) begin
            r.status = ST_GRID;
          end else begin
            n_walk_hits++;
            grid_occ[voxel_at(int'(ix), int'(iy), int'(iz))] = 1'b1;
            if (!c.occupied_only)
              trace_ray(NX / 2, NY / 2, 0, int'(ix) - NX / 2, int'(iy) - NY / 2, int'(iz));
          end
        end
      end
      CMD_QUERY: begin
        n_query++;
        if (c.query_x >= NX || c.query_y >= NY || c.query_z >= NZ) begin
          r.status = ST_GRID;
        end else if (seen_point) begin
          i = voxel_at(c.query_x, c.query_y, c.query_z);
          v = grid_count[i];
          pk = peak_count;
          if (grid_occ[i]) r.cost = '0;
          else if (v <= cfg.free_limit) r.cost = COST_FREE;
          else if (v > cfg.busy_limit) r.cost = '0;
          else if (pk == 0) r.cost = COST_FREE;
          else r.cost = 8'((pk - v) * 255 / pk);
        end
      end
      default: n_nop++;
    endcase
    return r;
  endfunction

  always @(posedge clk_i) begin
    vrtcg_out_t want;
    if (result_valid_o) begin
      results_seen++;
      if (pending_results.size() == 0) begin
        mismatches++;
        if (mismatches <= 10) $display("unexpected result beat: %p", result_o);
      end else begin
        want = pending_results.pop_front();
        if (result_o.status !== want.status || result_o.cost !== want.cost) begin
          mismatches++;
          if (mismatches <= 10)
            $display("mismatch: status exp %0d got %0d, cost exp %0d got %0d",
                     want.status, result_o.status, want.cost, result_o.cost);
        end
      end
    end
  end

  task automatic issue(vrtcg_in_t c, bit typed, vrtcg_out_t typed_res);
    int gap, pick;
    vrtcg_out_t p;
    pick = $urandom_range(0, 99);
    gap = no_gaps ? 0 : (pick < 60 ? 0 : (pick < 92 ? $urandom_range(1, 3)
                                                     : $urandom_range(10, 80)));
    if (gap > 0) begin
      start <= 1'b0;
      repeat (gap) @(posedge clk_i);
    end
    cmd_i <= c;
    start <= 1'b1;
    do @(posedge clk_i); while (busy);
    p = predict_grid(c);
    if (typed) p = typed_res;
    pending_results = {pending_results, p};
  endtask

  task automatic settle();
    start <= 1'b0;
    @(posedge clk_i);
    while (pending_results.size() != 0) @(posedge clk_i);
    repeat (20) @(posedge clk_i);
    while (busy) @(posedge clk_i);
  endtask

  task automatic write_reg(logic [1:0] idx, logic [15:0] val);
    cfg_we_i <= 1'b1;
    cfg_idx_i <= idx;
    cfg_data_i <= val;
    @(posedge clk_i);
    cfg_we_i <= 1'b0;
    case (idx)
      CFG_INV_RES:   cfg.inv_resolution = val;
      CFG_MAX_RANGE: cfg.max_range = val;
      CFG_FREE_LIM:  cfg.free_limit = val;
      default:       cfg.busy_limit = val;
    endcase
  endtask

  task automatic set_config(logic [15:0] inv, logic [15:0] mr, logic [15:0] fl,
                            logic [15:0] bl);
    settle();
    write_reg(CFG_INV_RES, inv);
    write_reg(CFG_MAX_RANGE, mr);
    write_reg(CFG_FREE_LIM, fl);
    write_reg(CFG_BUSY_LIM, bl);
    @(posedge clk_i);
  endtask

  function automatic logic [15:0] rand_pos(int lo, int hi);
    if ($urandom_range(0, 19) == 0) return 16'($urandom);
    return 16'($urandom_range(0, hi - lo) + lo);
  endfunction

  function automatic vrtcg_in_t random_item();
    vrtcg_in_t c;
    int pick, span;
    c = vrtcg_in_t'({$urandom, $urandom});
    pick = $urandom_range(0, 999);
    span = (NX / 2 * (1 << FRAC_W)) / cfg.inv_resolution;
    if (span > 32767) span = 32767;
    if (span < 4) span = 4;
    if (pick < 3) c.cmd = CMD_CLEAR;
    else if (pick < 560) c.cmd = CMD_ADD;
    else if (pick < 980) c.cmd = CMD_QUERY;
    else c.cmd = OP_NOP;
    if (c.cmd == CMD_ADD) begin
      c.pos_x = rand_pos(-span - span / 8, span);
      c.pos_y = rand_pos(-span - span / 8, span);
      c.pos_z = rand_pos(-span / 8, (2 * span > 32767) ? 32767 : 2 * span);
      c.occupied_only = ($urandom_range(0, 4) == 0);
    end else if (c.cmd == CMD_QUERY && $urandom_range(0, 1)) begin
      c.query_x = 5'($urandom_range(NX / 2 - 6, NX / 2 + 5));
      c.query_y = 5'($urandom_range(NY / 2 - 6, NY / 2 + 5));
      c.query_z = 5'($urandom_range(0, 12));
    end
    return c;
  endfunction

  function automatic stim_row_t mk(logic [1:0] op, int x, int y, int z, bit oo,
                                   int qx, int qy, int qz, bit typed,
                                   logic [1:0] st, logic [7:0] cost);
    stim_row_t r;
    r.cmd = '{cmd: op, pos_x: 16'(x), pos_y: 16'(y), pos_z: 16'(z), occupied_only: oo,
              query_x: 5'(qx), query_y: 5'(qy), query_z: 5'(qz)};
    r.typed = typed;
    r.res = '{status: st, cost: cost};
    return r;
  endfunction

  stim_row_t directed [$];

  initial begin
    clear_grid();
    cfg = '{inv_resolution: 16'd2560, max_range: 16'd5120, free_limit: 16'd0,
            busy_limit: 16'hFFFF};
    directed = '{
      mk(CMD_QUERY, 0, 0, 0, 0, 0, 0, 0, 1, ST_DONE, 0),
      mk(CMD_QUERY, 0, 0, 0, 0, 31, 31, 31, 1, ST_DONE, 0),
      mk(OP_NOP, -1, -1, -1, 1, 31, 31, 31, 1, ST_DONE, 0),
      mk(CMD_ADD, 32767, 0, 0, 0, 0, 0, 0, 1, ST_RANGE, 0),
      mk(CMD_ADD, -32768, -32768, -32768, 1, 0, 0, 0, 1, ST_RANGE, 0),
      mk(CMD_ADD, 0, 0, -200, 0, 0, 0, 0, 1, ST_GRID, 0),
      mk(CMD_ADD, 0, 0, 0, 0, 0, 0, 0, 1, ST_DONE, 0),
      mk(CMD_QUERY, 0, 0, 0, 0, 16, 16, 0, 1, ST_DONE, 0),
      mk(CMD_QUERY, 0, 0, 0, 0, 0, 0, 0, 1, ST_DONE, COST_FREE),
      mk(CMD_ADD, 0, 0, -50, 0, 0, 0, 0, 1, ST_DONE, 0),
      mk(CMD_ADD, 1600, -1600, 3000, 0, 0, 0, 0, 1, ST_DONE, 0),
      mk(CMD_ADD, -1600, 1600, 3000, 1, 0, 0, 0, 1, ST_DONE, 0),
      mk(CMD_ADD, 300, 200, 1000, 0, 0, 0, 0, 0, 0, 0),
      mk(CMD_ADD, 300, 200, 1000, 0, 0, 0, 0, 0, 0, 0),
      mk(CMD_QUERY, 0, 0, 0, 0, 31, 0, 29, 1, ST_DONE, 0),
      mk(CMD_QUERY, 0, 0, 0, 0, 16, 16, 1, 0, 0, 0),
      mk(CMD_QUERY, 0, 0, 0, 0, 17, 17, 5, 0, 0, 0),
      mk(CMD_QUERY, 0, 0, 0, 0, 30, 1, 28, 0, 0, 0),
      mk(CMD_CLEAR, 0, 0, 0, 0, 0, 0, 0, 1, ST_DONE, 0),
      mk(CMD_QUERY, 0, 0, 0, 0, 16, 17, 0, 1, ST_DONE, 0)
    };
    repeat (11) @(posedge clk_i);
    rst_ni <= 1'b1;
    @(posedge clk_i);
    while (busy) @(posedge clk_i);
    foreach (directed[i]) issue(directed[i].cmd, directed[i].typed, directed[i].res);

    for (int ph = 0; ph < 5; ph++) begin
      case (ph)
        1: set_config(16'hFFFF, 16'hFFFF, 16'd2, 16'd40);
        2: set_config(16'd1, 16'd0, 16'd0, 16'd0);
        3: set_config(16'd5000, 16'd3000, 16'hFFFF, 16'hFFFF);
        4: set_config(16'd2560, 16'hFFFF, 16'd1, 16'hFFFE);
        default: ;
      endcase
      for (int n = 0; n < PHASE_ITEMS; n++) begin
        no_gaps = (n % 100) >= 80;
        issue(random_item(), 1'b0, '0);
      end
    end
    settle();
    repeat (200) @(posedge clk_i);
    $display("Covered %0d add-point, %0d query, %0d clear and %0d unused-code beats;",
             n_add, n_query, n_clear, n_nop);
    $display("%0d points landed in the grid, %0d results checked over five settings.",
             n_walk_hits, results_seen);
    if (mismatches == 0 && pending_results.size() == 0) begin
      $display("tb_voxel_ray_trace_cost_grid_core OK");
    end else begin
      $display("%0d mismatches, %0d results missing", mismatches, pending_results.size());
      $display("tb_voxel_ray_trace_cost_grid_core NOT OK");
    end
    $finish;
  end

  initial begin
    #20_000_000;
    $display("timeout with %0d results outstanding", pending_results.size());
    $display("tb_voxel_ray_trace_cost_grid_core NOT OK");
    $finish;
  end

endmodule
